@@ rtl/core/indexed_min_heap_priority_queue_defines.svh @@
// assertion macros for the indexed min-heap priority queue
// no dependencies; included by the top level only
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IMHPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMHPQ_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IMHPQ_ASSERT(lbl, clk, rst, prop, msg)
`define IMHPQ_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ rtl/core/imhpq_pkg.sv @@
// shared types and constants of the indexed min-heap priority queue
// no dependencies
package imhpq_pkg;

  localparam int HEAP_CAPACITY_DEF = 1024;
  localparam int NODE_IDS_DEF      = 4096;
  localparam int COST_BITS_DEF     = 24;
  localparam int ID_BITS           = 12;
  localparam int REQ_BITS          = 3;
  localparam int STATUS_BITS       = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CHANGE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_PR1, S_PR2, S_INS, S_P1, S_P2, S_P3, S_P4,
    S_R1, S_R2, S_R3, S_C1, S_SU0, S_SU1, S_SU2, S_SD0, S_SD1, S_SD2, S_SD3,
    S_WB, S_FIN
  } ctl_state_t;

  typedef enum logic [4:0] {
    U_INIT, U_IDLE, U_DEC, U_PR1, U_PR2, U_INS, U_P1, U_P2, U_P3, U_P4,
    U_R1, U_R2, U_R3, U_C1, U_SU0, U_SU1, U_SU2, U_SD0, U_SD1, U_SD2, U_SD3,
    U_WB, U_FIN
  } uop_t;

  typedef struct packed {
    uop_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_BITS-1:0] req;
    logic init_done;
    logic accept;
    logic id_ok;
    logic count_zero;
    logic present;
    logic full;
    logic mid_in;
    logic key_lt;
    logic cost_lt;
    logic at_zero;
    logic l_lt;
    logic sd_go;
    logic out_free;
  } dp_flags_t;

endpackage

@@ rtl/core/imhpq_ctrl.sv @@
// sequencer of the indexed min-heap priority queue
// depends on imhpq_pkg
module imhpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  imhpq_pkg::dp_flags_t flags,
  output imhpq_pkg::dp_cmd_t   cmd
);

  imhpq_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imhpq_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      imhpq_pkg::S_INIT: if (flags.init_done) state_next = imhpq_pkg::S_IDLE;
      imhpq_pkg::S_IDLE: if (flags.accept) state_next = imhpq_pkg::S_DEC;
      imhpq_pkg::S_DEC: begin
        case (flags.req)
          imhpq_pkg::REQ_INSERT, imhpq_pkg::REQ_REMOVE, imhpq_pkg::REQ_CHANGE:
            state_next = flags.id_ok ? imhpq_pkg::S_PR1 : imhpq_pkg::S_FIN;
          imhpq_pkg::REQ_POP, imhpq_pkg::REQ_PEEK:
            state_next = flags.count_zero ? imhpq_pkg::S_FIN : imhpq_pkg::S_P1;
          default: state_next = imhpq_pkg::S_FIN;
        endcase
      end
      imhpq_pkg::S_PR1: state_next = imhpq_pkg::S_PR2;
      imhpq_pkg::S_PR2: begin
        case (flags.req)
          imhpq_pkg::REQ_INSERT:
            state_next = (flags.present || flags.full) ? imhpq_pkg::S_FIN
                                                       : imhpq_pkg::S_INS;
          imhpq_pkg::REQ_REMOVE:
            state_next = flags.present ? imhpq_pkg::S_R1 : imhpq_pkg::S_FIN;
          imhpq_pkg::REQ_CHANGE:
            state_next = flags.present ? imhpq_pkg::S_C1 : imhpq_pkg::S_FIN;
          default: state_next = imhpq_pkg::S_FIN;
        endcase
      end
      imhpq_pkg::S_INS: state_next = imhpq_pkg::S_SU0;
      imhpq_pkg::S_P1:  state_next = imhpq_pkg::S_P2;
      imhpq_pkg::S_P2:
        state_next = (flags.req == imhpq_pkg::REQ_POP) ? imhpq_pkg::S_P3
                                                       : imhpq_pkg::S_FIN;
      imhpq_pkg::S_P3:
        state_next = flags.count_zero ? imhpq_pkg::S_FIN : imhpq_pkg::S_P4;
      imhpq_pkg::S_P4: state_next = imhpq_pkg::S_SD0;
      imhpq_pkg::S_R1: state_next = flags.mid_in ? imhpq_pkg::S_R2 : imhpq_pkg::S_FIN;
      imhpq_pkg::S_R2: state_next = imhpq_pkg::S_R3;
      imhpq_pkg::S_R3: state_next = flags.key_lt ? imhpq_pkg::S_SU0 : imhpq_pkg::S_SD0;
      imhpq_pkg::S_C1: state_next = flags.cost_lt ? imhpq_pkg::S_SU0 : imhpq_pkg::S_SD0;
      imhpq_pkg::S_SU0: state_next = flags.at_zero ? imhpq_pkg::S_WB : imhpq_pkg::S_SU1;
      imhpq_pkg::S_SU1: state_next = imhpq_pkg::S_SU2;
      imhpq_pkg::S_SU2: state_next = flags.key_lt ? imhpq_pkg::S_SU0 : imhpq_pkg::S_WB;
      imhpq_pkg::S_SD0: state_next = flags.l_lt ? imhpq_pkg::S_SD1 : imhpq_pkg::S_WB;
      imhpq_pkg::S_SD1: state_next = imhpq_pkg::S_SD2;
      imhpq_pkg::S_SD2: state_next = imhpq_pkg::S_SD3;
      imhpq_pkg::S_SD3: state_next = flags.sd_go ? imhpq_pkg::S_SD0 : imhpq_pkg::S_WB;
      imhpq_pkg::S_WB:  state_next = imhpq_pkg::S_FIN;
      imhpq_pkg::S_FIN: if (flags.out_free) state_next = imhpq_pkg::S_IDLE;
      default: state_next = imhpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      imhpq_pkg::S_INIT: cmd.op = imhpq_pkg::U_INIT;
      imhpq_pkg::S_IDLE: cmd.op = imhpq_pkg::U_IDLE;
      imhpq_pkg::S_DEC:  cmd.op = imhpq_pkg::U_DEC;
      imhpq_pkg::S_PR1:  cmd.op = imhpq_pkg::U_PR1;
      imhpq_pkg::S_PR2:  cmd.op = imhpq_pkg::U_PR2;
      imhpq_pkg::S_INS:  cmd.op = imhpq_pkg::U_INS;
      imhpq_pkg::S_P1:   cmd.op = imhpq_pkg::U_P1;
      imhpq_pkg::S_P2:   cmd.op = imhpq_pkg::U_P2;
      imhpq_pkg::S_P3:   cmd.op = imhpq_pkg::U_P3;
      imhpq_pkg::S_P4:   cmd.op = imhpq_pkg::U_P4;
      imhpq_pkg::S_R1:   cmd.op = imhpq_pkg::U_R1;
      imhpq_pkg::S_R2:   cmd.op = imhpq_pkg::U_R2;
      imhpq_pkg::S_R3:   cmd.op = imhpq_pkg::U_R3;
      imhpq_pkg::S_C1:   cmd.op = imhpq_pkg::U_C1;
      imhpq_pkg::S_SU0:  cmd.op = imhpq_pkg::U_SU0;
      imhpq_pkg::S_SU1:  cmd.op = imhpq_pkg::U_SU1;
      imhpq_pkg::S_SU2:  cmd.op = imhpq_pkg::U_SU2;
      imhpq_pkg::S_SD0:  cmd.op = imhpq_pkg::U_SD0;
      imhpq_pkg::S_SD1:  cmd.op = imhpq_pkg::U_SD1;
      imhpq_pkg::S_SD2:  cmd.op = imhpq_pkg::U_SD2;
      imhpq_pkg::S_SD3:  cmd.op = imhpq_pkg::U_SD3;
      imhpq_pkg::S_WB:   cmd.op = imhpq_pkg::U_WB;
      imhpq_pkg::S_FIN:  cmd.op = imhpq_pkg::U_FIN;
      default:           cmd.op = imhpq_pkg::U_IDLE;
    endcase
  end

endmodule

@@ rtl/core/imhpq_dp.sv @@
// datapath of the indexed min-heap priority queue: slot, position and key memories
// depends on imhpq_pkg
module imhpq_dp #(
  parameter int HEAP_CAPACITY = imhpq_pkg::HEAP_CAPACITY_DEF,
  parameter int NODE_IDS      = imhpq_pkg::NODE_IDS_DEF,
  parameter int COST_BITS     = imhpq_pkg::COST_BITS_DEF,
  parameter int CW            = $clog2(HEAP_CAPACITY + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  imhpq_pkg::dp_cmd_t                   cmd,
  output imhpq_pkg::dp_flags_t                 flags,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [imhpq_pkg::REQ_BITS-1:0]       in_req,
  input  logic [imhpq_pkg::ID_BITS-1:0]        in_id,
  input  logic [COST_BITS-1:0]                 in_cost,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [imhpq_pkg::STATUS_BITS-1:0]    out_status,
  output logic [imhpq_pkg::ID_BITS-1:0]        out_node,
  output logic [COST_BITS-1:0]                 out_cost,
  output logic [CW-1:0]                        out_total,
  output logic                                 out_empty
);

  localparam int PW  = $clog2(HEAP_CAPACITY);
  localparam int NIW = $clog2(NODE_IDS);
  localparam int IDB = imhpq_pkg::ID_BITS;

  function automatic logic [NIW-1:0] to_nidx(input logic [IDB-1:0] v);
    logic [NIW+IDB-1:0] w;
    w = (NIW+IDB)'(v);
    return w[NIW-1:0];
  endfunction

  // memories
  logic [IDB-1:0]       slot_mem [HEAP_CAPACITY];
  logic [PW-1:0]        pos_mem  [NODE_IDS];
  logic [COST_BITS-1:0] key_mem  [NODE_IDS];

  logic                 slot_we, pos_we, key_we;
  logic [PW-1:0]        slot_addr;
  logic [IDB-1:0]       slot_wd, slot_rd;
  logic [NIW-1:0]       pos_addr, key_addr;
  logic [PW-1:0]        pos_wd, pos_rd;
  logic [COST_BITS-1:0] key_wd, key_rd;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_addr] <= slot_wd;
    slot_rd <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wd;
    pos_rd <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_addr] <= key_wd;
    key_rd <= key_mem[key_addr];
  end

  // working registers
  logic [imhpq_pkg::REQ_BITS-1:0]    req;
  logic [IDB-1:0]                    rid, cur_id, aux_id, r_id;
  logic [COST_BITS-1:0]              rcost, cur_key, aux_key;
  logic [CW-1:0]                     count;
  logic [PW-1:0]                     at;
  logic                              hit;
  logic [NIW-1:0]                    clr_idx;
  logic [imhpq_pkg::STATUS_BITS-1:0] status;
  logic [IDB-1:0]                    nout;
  logic [COST_BITS-1:0]              cout;

  logic [PW-1:0]   up_idx;
  logic [PW:0]     l_idx;
  logic [PW+1:0]   r_idx;
  logic            l_lt, r_lt, present, take_left, sd_go, accept, out_free;
  logic [IDB-1:0]  pick_id;
  logic [COST_BITS-1:0] pick_key;
  logic [PW-1:0]   pick_idx;

  assign up_idx   = PW'((at - PW'(1)) >> 1);
  assign l_idx    = {at, 1'b1};
  assign r_idx    = (PW+2)'(l_idx) + (PW+2)'(1);
  assign l_lt     = 32'(l_idx) < 32'(count);
  assign r_lt     = 32'(r_idx) < 32'(count);
  assign present  = hit && (slot_rd == rid);
  assign take_left = !r_lt || (aux_key < key_rd);
  assign pick_id  = take_left ? aux_id : r_id;
  assign pick_key = take_left ? aux_key : key_rd;
  assign pick_idx = take_left ? l_idx[PW-1:0] : r_idx[PW-1:0];
  assign sd_go    = pick_key < cur_key;
  assign in_ready = (cmd.op == imhpq_pkg::U_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    flags.req        = req;
    flags.init_done  = (32'(clr_idx) == NODE_IDS - 1);
    flags.accept     = accept;
    flags.id_ok      = 32'(rid) < 32'(NODE_IDS);
    flags.count_zero = (count == '0);
    flags.present    = present;
    flags.full       = 32'(count) >= 32'(HEAP_CAPACITY);
    flags.mid_in     = 32'(count) > 32'(at);
    flags.key_lt     = cur_key < key_rd;
    flags.cost_lt    = rcost < key_rd;
    flags.at_zero    = (at == '0);
    flags.l_lt       = l_lt;
    flags.sd_go      = sd_go;
    flags.out_free   = out_free;
  end

  // memory port steering
  always_comb begin
    slot_we = 1'b0; slot_addr = at;       slot_wd = cur_id;
    pos_we  = 1'b0; pos_addr  = to_nidx(rid); pos_wd = at;
    key_we  = 1'b0; key_addr  = to_nidx(rid); key_wd = rcost;
    case (cmd.op)
      imhpq_pkg::U_INIT: begin
        pos_we = 1'b1; pos_addr = clr_idx; pos_wd = '0;
      end
      imhpq_pkg::U_DEC: slot_addr = '0;
      imhpq_pkg::U_PR1: slot_addr = pos_rd;
      imhpq_pkg::U_PR2: slot_addr = PW'(count - CW'(1));
      imhpq_pkg::U_INS: begin
        key_we  = 1'b1;
        slot_we = 1'b1; slot_addr = count[PW-1:0]; slot_wd = rid;
        pos_we  = 1'b1; pos_wd = count[PW-1:0];
      end
      imhpq_pkg::U_P1: key_addr = to_nidx(slot_rd);
      imhpq_pkg::U_P2: slot_addr = PW'(count - CW'(1));
      imhpq_pkg::U_P3: begin
        slot_we = 1'b1; slot_addr = '0; slot_wd = slot_rd;
        pos_we  = 1'b1; pos_addr = to_nidx(slot_rd); pos_wd = '0;
        key_addr = to_nidx(slot_rd);
      end
      imhpq_pkg::U_R1: begin
        slot_we = 1'b1; slot_wd = slot_rd;
        pos_we  = flags.mid_in; pos_addr = to_nidx(slot_rd);
        key_addr = to_nidx(slot_rd);
      end
      imhpq_pkg::U_C1: key_we = 1'b1;
      imhpq_pkg::U_SU0: slot_addr = up_idx;
      imhpq_pkg::U_SU1: key_addr = to_nidx(slot_rd);
      imhpq_pkg::U_SU2: begin
        slot_we = flags.key_lt; slot_wd = aux_id;
        pos_we  = flags.key_lt; pos_addr = to_nidx(aux_id);
      end
      imhpq_pkg::U_SD0: slot_addr = l_idx[PW-1:0];
      imhpq_pkg::U_SD1: begin
        key_addr  = to_nidx(slot_rd);
        slot_addr = r_idx[PW-1:0];
      end
      imhpq_pkg::U_SD2: key_addr = to_nidx(slot_rd);
      imhpq_pkg::U_SD3: begin
        slot_we = sd_go; slot_wd = pick_id;
        pos_we  = sd_go; pos_addr = to_nidx(pick_id);
      end
      imhpq_pkg::U_WB: begin
        slot_we = 1'b1;
        pos_we  = 1'b1; pos_addr = to_nidx(cur_id);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == imhpq_pkg::U_INIT) clr_idx <= clr_idx + NIW'(1);
      case (cmd.op)
        imhpq_pkg::U_DEC:
          if (req == imhpq_pkg::REQ_CLEAR) count <= '0;
        imhpq_pkg::U_PR2:
          if (req == imhpq_pkg::REQ_REMOVE && present) count <= count - CW'(1);
        imhpq_pkg::U_INS: count <= count + CW'(1);
        imhpq_pkg::U_P2:
          if (req == imhpq_pkg::REQ_POP) count <= count - CW'(1);
        default: ;
      endcase
      if (cmd.op == imhpq_pkg::U_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      imhpq_pkg::U_IDLE: if (accept) begin
        req <= in_req; rid <= in_id; rcost <= in_cost;
        status <= imhpq_pkg::ST_OK; nout <= '0; cout <= '0;
      end
      imhpq_pkg::U_DEC: begin
        if ((req == imhpq_pkg::REQ_POP || req == imhpq_pkg::REQ_PEEK) && count == '0)
          status <= imhpq_pkg::ST_EMPTY;
        if ((req == imhpq_pkg::REQ_INSERT || req == imhpq_pkg::REQ_REMOVE ||
             req == imhpq_pkg::REQ_CHANGE) && !flags.id_ok)
          status <= imhpq_pkg::ST_ABSENT;
      end
      imhpq_pkg::U_PR1: begin
        at  <= pos_rd;
        hit <= 32'(pos_rd) < 32'(count);
      end
      imhpq_pkg::U_PR2: begin
        if (req == imhpq_pkg::REQ_INSERT) begin
          if (present) status <= imhpq_pkg::ST_PRESENT;
          else if (flags.full) status <= imhpq_pkg::ST_FULL;
        end else if (!present) begin
          status <= imhpq_pkg::ST_ABSENT;
        end
      end
      imhpq_pkg::U_INS: begin
        at <= count[PW-1:0]; cur_id <= rid; cur_key <= rcost;
      end
      imhpq_pkg::U_P1: nout <= slot_rd;
      imhpq_pkg::U_P2: cout <= key_rd;
      imhpq_pkg::U_P3: begin
        cur_id <= slot_rd; at <= '0;
      end
      imhpq_pkg::U_P4: cur_key <= key_rd;
      imhpq_pkg::U_R1: cur_id <= slot_rd;
      imhpq_pkg::U_R2: cur_key <= key_rd;
      imhpq_pkg::U_C1: begin
        cur_id <= rid; cur_key <= rcost;
      end
      imhpq_pkg::U_SU1: aux_id <= slot_rd;
      imhpq_pkg::U_SU2: if (flags.key_lt) at <= up_idx;
      imhpq_pkg::U_SD1: aux_id <= slot_rd;
      imhpq_pkg::U_SD2: begin
        aux_key <= key_rd; r_id <= slot_rd;
      end
      imhpq_pkg::U_SD3: if (sd_go) at <= pick_idx;
      imhpq_pkg::U_FIN: if (out_free) begin
        out_status <= status;
        out_node   <= nout;
        out_cost   <= cout;
        out_total  <= count;
        out_empty  <= (count == '0);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/indexed_min_heap_priority_queue.sv @@
// indexed binary min-heap priority queue: one request in, one result out
// from accept to result valid: the request is decoded; insert, remove and change look up
//   the node position, pop and peek read the root; then the heap is sifted up or down where
//   needed and written back (each sift step waits on a registered slot read, then a key read)
// requests: one at a time; a result waits until the output is free, and only then is the next taken
// reset: node position table swept to zero first; slots, keys not cleared
`include "indexed_min_heap_priority_queue_defines.svh"
module indexed_min_heap_priority_queue #(
  parameter int HEAP_CAPACITY = imhpq_pkg::HEAP_CAPACITY_DEF,
  parameter int NODE_IDS      = imhpq_pkg::NODE_IDS_DEF,
  parameter int COST_BITS     = imhpq_pkg::COST_BITS_DEF,
  parameter int CW            = $clog2(HEAP_CAPACITY + 1),
  parameter int S_DATA_W      = ((imhpq_pkg::ID_BITS + COST_BITS + 7) / 8) * 8,
  parameter int M_DATA_W      = ((imhpq_pkg::ID_BITS + COST_BITS + CW + 1 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // node_id, cost
  input  logic [S_DATA_W-1:0]                s_tdata,
  // req_type
  input  logic [imhpq_pkg::REQ_BITS-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // node_out, cost_out, entry_total, is_empty
  output logic [M_DATA_W-1:0]                m_tdata,
  // status
  output logic [imhpq_pkg::STATUS_BITS-1:0]  m_tuser
);

  imhpq_pkg::dp_cmd_t   cmd;
  imhpq_pkg::dp_flags_t flags;

  // unpacked result fields
  logic [imhpq_pkg::ID_BITS-1:0] node_out;
  logic [COST_BITS-1:0]          cost_out;
  logic [CW-1:0]                 entry_total;
  logic                          is_empty;

  // sequencer: one state per memory access step
  imhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cmd   (cmd)
  );

  // memories, sift registers and the output register
  imhpq_dp #(
    .HEAP_CAPACITY (HEAP_CAPACITY),
    .NODE_IDS      (NODE_IDS),
    .COST_BITS     (COST_BITS),
    .CW            (CW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .flags      (flags),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (s_tuser),
    .in_id      (s_tdata[imhpq_pkg::ID_BITS-1:0]),
    .in_cost    (s_tdata[imhpq_pkg::ID_BITS +: COST_BITS]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_node   (node_out),
    .out_cost   (cost_out),
    .out_total  (entry_total),
    .out_empty  (is_empty)
  );

  // pack result beat, lowest field first, zero filled to whole bytes
  assign m_tdata = M_DATA_W'({is_empty, entry_total, cost_out, node_out});

  // count stays within capacity
  `IMHPQ_ASSERT(a_total_cap, clk, rst, m_tvalid |-> (32'(entry_total) <= HEAP_CAPACITY), "entry total above capacity")
  // empty flag matches the count
  `IMHPQ_ASSERT(a_empty_flag, clk, rst, m_tvalid |-> (is_empty == (entry_total == '0)), "empty flag mismatch")
  // failed requests carry no node or cost
  `IMHPQ_ASSERT(a_fail_zero, clk, rst, (m_tvalid && m_tuser != imhpq_pkg::ST_OK) |-> (node_out == '0 && cost_out == '0), "nonzero payload on failed request")
  // a request in flight blocks the next one
  `IMHPQ_NEVER(a_one_at_time, clk, rst, $past(s_tvalid && s_tready) && s_tready, "ready right after accept")

endmodule
